/* sv/scsu_pkg.sv */
// Shared types and codes for the shadow call stack unwind core.
// Holds the request and response words and the controller/datapath link.
// No dependencies.
package scsu_pkg;

  localparam logic [1:0] KIND_CALL  = 2'd0;
  localparam logic [1:0] KIND_RET   = 2'd1;
  localparam logic [1:0] KIND_QUERY = 2'd2;
  localparam logic [1:0] KIND_NONE  = 2'd3;

  localparam int DEPTH_OUT_W = 7;

  typedef struct packed {
    logic [1:0]  kind;
    logic [63:0] caller_id;
    logic [63:0] pc;
    logic [4:0]  level;
  } req_t;

  typedef struct packed {
    logic                   valid_res;
    logic [63:0]            reported_id;
    logic                   last;
    logic                   matched;
    logic                   overflow;
    logic [DEPTH_OUT_W-1:0] depth_now;
  } rsp_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic take_req;     // controller is idle and can take a request word
    logic clr_flags;
    logic push;         // write the latched pair at the top and grow the stack
    logic set_ovf;
    logic load_ptr;     // pointer to the top entry, count to the query length
    logic ptr_dec;
    logic ret_rd;
    logic id_rd;
    logic hit_pop;      // unwind to the entry under the pointer
    logic load_status;
    logic load_query;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [1:0] kind;
    logic       req_valid;
    logic       depth_zero;
    logic       depth_full;
    logic       qn_zero;
    logic       hit;
    logic       ptr_zero;
    logic       rem_one;
    logic       rsp_free;
  } stat_t;

endpackage

/* sv/scsu_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// Used for the caller id and return address stores; no dependencies.
module scsu_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* sv/scsu_ctrl.sv */
// Sequencing state machine for the shadow call stack unwind core.
// Depends on scsu_pkg for the command and status structs and kind codes.
module scsu_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  scsu_pkg::stat_t stat,
  output scsu_pkg::cmd_t  cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECODE = 3'd1;
  localparam logic [2:0] S_STATUS = 3'd2;
  localparam logic [2:0] S_SRD    = 3'd3;
  localparam logic [2:0] S_SCMP   = 3'd4;
  localparam logic [2:0] S_QRD    = 3'd5;
  localparam logic [2:0] S_QOUT   = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        cmd.take_req = 1'b1;
        if (stat.req_valid) begin
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd.clr_flags = 1'b1;
        unique case (stat.kind)
          scsu_pkg::KIND_CALL: begin
            if (stat.depth_full) begin
              cmd.set_ovf = 1'b1;
            end else begin
              cmd.push = 1'b1;
            end
            state_next = S_STATUS;
          end
          scsu_pkg::KIND_RET: begin
            if (stat.depth_zero) begin
              state_next = S_STATUS;
            end else begin
              cmd.load_ptr = 1'b1;
              state_next   = S_SRD;
            end
          end
          scsu_pkg::KIND_QUERY: begin
            if (stat.qn_zero) begin
              state_next = S_STATUS;
            end else begin
              cmd.load_ptr = 1'b1;
              state_next   = S_QRD;
            end
          end
          default: begin
            state_next = S_STATUS;
          end
        endcase
      end
      S_STATUS: begin
        if (stat.rsp_free) begin
          cmd.load_status = 1'b1;
          state_next      = S_IDLE;
        end
      end
      S_SRD: begin
        cmd.ret_rd = 1'b1;
        state_next = S_SCMP;
      end
      S_SCMP: begin
        // Search runs from the top down, so the first hit is the topmost match.
        if (stat.hit) begin
          cmd.hit_pop = 1'b1;
          state_next  = S_STATUS;
        end else if (stat.ptr_zero) begin
          state_next = S_STATUS;
        end else begin
          cmd.ptr_dec = 1'b1;
          state_next  = S_SRD;
        end
      end
      S_QRD: begin
        cmd.id_rd  = 1'b1;
        state_next = S_QOUT;
      end
      S_QOUT: begin
        if (stat.rsp_free) begin
          cmd.load_query = 1'b1;
          if (stat.rem_one) begin
            state_next = S_IDLE;
          end else begin
            cmd.ptr_dec = 1'b1;
            state_next  = S_QRD;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

/* sv/scsu_dp.sv */
// Datapath of the shadow call stack unwind core: request latch, stack
// memories, depth, scan pointer and the response register.
// Depends on scsu_pkg and scsu_ram.
module scsu_dp #(
  parameter int STACK_DEPTH = 64,
  parameter int MAX_QUERY   = 16
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  input  scsu_pkg::req_t  req,
  input  logic            rsp_stall,
  output logic            rsp_valid,
  output scsu_pkg::rsp_t  rsp,
  input  scsu_pkg::cmd_t  cmd,
  output scsu_pkg::stat_t stat
);

  localparam int AW  = $clog2(STACK_DEPTH);
  localparam int DW  = $clog2(STACK_DEPTH + 1);
  localparam int QW  = $clog2(MAX_QUERY + 1);
  localparam int NW0 = (DW > QW) ? DW : QW;
  localparam int NW  = (NW0 > 5) ? NW0 : 5;

  scsu_pkg::req_t item;
  logic [DW-1:0]  depth;
  logic [AW-1:0]  ptr;
  logic [QW-1:0]  rem;
  logic           matched;
  logic           overflow;
  scsu_pkg::rsp_t rsp_q;

  logic [63:0]   id_rdata;
  logic [63:0]   ret_rdata;
  logic [DW-1:0] depth_m1;
  logic [NW-1:0] lvl_sat;
  logic [NW-1:0] qn;
  logic          rsp_free;

  assign depth_m1 = depth - DW'(1);
  assign rsp_free = !rsp_valid || !rsp_stall;

  // Query length is min(level, MAX_QUERY, depth).
  always_comb begin
    lvl_sat = NW'(item.level);
    if (lvl_sat > NW'(MAX_QUERY)) begin
      lvl_sat = NW'(MAX_QUERY);
    end
    qn = lvl_sat;
    if (qn > NW'(depth)) begin
      qn = NW'(depth);
    end
  end

  scsu_ram #(.WIDTH(64), .DEPTH(STACK_DEPTH)) u_id_ram (
    .clk   (clk),
    .we    (cmd.push),
    .waddr (depth[AW-1:0]),
    .wdata (item.caller_id),
    .re    (cmd.id_rd),
    .raddr (ptr),
    .rdata (id_rdata)
  );

  scsu_ram #(.WIDTH(64), .DEPTH(STACK_DEPTH)) u_ret_ram (
    .clk   (clk),
    .we    (cmd.push),
    .waddr (depth[AW-1:0]),
    .wdata (item.pc),
    .re    (cmd.ret_rd),
    .raddr (ptr),
    .rdata (ret_rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.take_req && req_valid) begin
      item <= req;
    end
    // Decode clears both flags; a flag set in the same cycle takes the place of the clear.
    if (cmd.clr_flags || cmd.hit_pop) begin
      matched <= cmd.hit_pop;
    end
    if (cmd.clr_flags || cmd.set_ovf) begin
      overflow <= cmd.set_ovf;
    end
    if (cmd.load_ptr) begin
      ptr <= depth_m1[AW-1:0];
      rem <= qn[QW-1:0];
    end else if (cmd.ptr_dec) begin
      ptr <= ptr - AW'(1);
      rem <= rem - QW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      depth <= '0;
    end else if (cmd.push) begin
      depth <= depth + DW'(1);
    end else if (cmd.hit_pop) begin
      depth <= DW'(ptr);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.load_status || cmd.load_query) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_status) begin
      rsp_q.valid_res   <= 1'b0;
      rsp_q.reported_id <= '0;
      rsp_q.last        <= 1'b1;
      rsp_q.matched     <= matched;
      rsp_q.overflow    <= overflow;
      rsp_q.depth_now   <= scsu_pkg::DEPTH_OUT_W'(depth);
    end else if (cmd.load_query) begin
      rsp_q.valid_res   <= 1'b1;
      rsp_q.reported_id <= id_rdata;
      rsp_q.last        <= (rem == QW'(1));
      rsp_q.matched     <= 1'b0;
      rsp_q.overflow    <= 1'b0;
      rsp_q.depth_now   <= scsu_pkg::DEPTH_OUT_W'(depth);
    end
  end

  assign rsp = rsp_q;

  assign stat.kind       = item.kind;
  assign stat.req_valid  = req_valid;
  assign stat.depth_zero = (depth == '0);
  assign stat.depth_full = (depth == DW'(STACK_DEPTH));
  assign stat.qn_zero    = (qn == '0);
  assign stat.hit        = (ret_rdata == item.pc);
  assign stat.ptr_zero   = (ptr == '0);
  assign stat.rem_one    = (rem == QW'(1));
  assign stat.rsp_free   = rsp_free;

endmodule

/* sv/shadow_call_stack_unwind_core.sv */
// Channel  Signals                      Direction  Word
// req      req_valid, req_stall, req    in         scsu_pkg::req_t
// rsp      rsp_valid, rsp_stall, rsp    out        scsu_pkg::rsp_t
//
// Call and unused kinds go from decode straight to the status load. A return
// searches from the top; each return address is read from memory, then compared.
// A query reads each id from memory and then loads it into the output register.
// Reset clears the depth and the controller; the stores need no clearing.
// A stalled response register holds the controller in its output states;
// one finished word may wait there while the next request word is taken.
module shadow_call_stack_unwind_core #(
  parameter int STACK_DEPTH = 64,
  parameter int MAX_QUERY   = 16
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  input  scsu_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output scsu_pkg::rsp_t rsp
);

  scsu_pkg::cmd_t  cmd;
  scsu_pkg::stat_t stat;

  assign req_stall = !cmd.take_req;

  scsu_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .cmd  (cmd)
  );

  scsu_dp #(
    .STACK_DEPTH (STACK_DEPTH),
    .MAX_QUERY   (MAX_QUERY)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req       (req),
    .rsp_stall (rsp_stall),
    .rsp_valid (rsp_valid),
    .rsp       (rsp),
    .cmd       (cmd),
    .stat      (stat)
  );

endmodule
